[rtl/sri_pkg.sv]
// Shared types and constants for the smallest-denominator fraction block.
// Depends on nothing; every other file imports this package.
`default_nettype none

package sri_pkg;

    localparam int IN_W     = 33;
    localparam int OUT_W    = 33;
    localparam int STEP_W   = 7;
    localparam int STATUS_W = 2;

    localparam int FRAC_BITS_DEFAULT = 32;
    localparam int MAX_STEPS_DEFAULT = 64;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_INVALID = 2'd1;
    localparam status_t STATUS_CAP     = 2'd2;

    typedef struct packed {
        logic [IN_W-1:0] lower_bound;
        logic [IN_W-1:0] upper_bound;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0]  numerator;
        logic [OUT_W-1:0]  denominator;
        logic [STEP_W-1:0] step_count;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

[rtl/sri_div.sv]
// Restoring serial divider, one quotient bit per cycle, floor or ceiling.
// Depends on sri_pkg for the default width.
`default_nettype none

module sri_div #(
    parameter int W = sri_pkg::FRAC_BITS_DEFAULT + 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         round_up,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    import sri_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic          run_reg;
    logic          run_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  quo_next;
    logic [W-1:0]  dvs_reg;
    logic [W-1:0]  dvs_next;
    logic          up_reg;
    logic          up_next;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        up_next   = up_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(W);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            up_next  = round_up;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        up_reg  <= up_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg + W'(up_reg && (rem_reg != '0));

endmodule

`default_nettype wire

[rtl/smallest_rational_in_interval.sv]
// Top level: sequencer, residual and convergent registers, serial multiply-accumulate.
// Depends on sri_pkg and sri_div.
//
// Takes one interval [lower_bound, upper_bound] (fractions scaled by 2^FRAC_BITS) per
// transaction and returns the fraction of smallest denominator inside it, found by a
// two-sided continued-fraction recurrence in exact integers. item_ready is high only
// while the block is idle; the finished result waits in an output register, so the next
// transaction may start before it is taken. A reversed, out-of-range or zero-lower
// interval goes from acceptance straight to the result load. Otherwise each iteration
// runs a check state, the two serial dividers side by side (FRAC_BITS + 2 quotient bits
// each, then a done), four products on one shared shift-add unit, each loaded and then
// run, and an update state. At most MAX_STEPS iterations are run.
`default_nettype none

module smallest_rational_in_interval #(
    parameter int FRAC_BITS = sri_pkg::FRAC_BITS_DEFAULT,
    parameter int MAX_STEPS = sri_pkg::MAX_STEPS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sri_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output sri_pkg::result_t  result
);
    import sri_pkg::*;

    localparam int RW       = FRAC_BITS + 3;
    localparam int NW       = RW - 1;
    localparam int AW       = (RW > OUT_W) ? RW : OUT_W;
    localparam int SCW      = $clog2(MAX_STEPS + 1);
    localparam int SW       = (SCW > STEP_W) ? SCW : STEP_W;
    localparam int STEP_MAX = (2 ** STEP_W) - 1;
    localparam logic [AW-1:0] SCALE = AW'(1) << FRAC_BITS;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CHECK  = 7'b0000010,
        ST_DIV    = 7'b0000100,
        ST_LOAD   = 7'b0001000,
        ST_RUN    = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        OP_P = 2'd0,
        OP_Q = 2'd1,
        OP_E = 2'd2,
        OP_F = 2'd3
    } op_t;

    state_t state_reg;
    state_t state_next;
    op_t    op_reg;
    op_t    op_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    result_t result_reg;
    result_t result_next;

    logic [OUT_W-1:0] pa_reg, pa_next, qa_reg, qa_next;
    logic [OUT_W-1:0] pb_reg, pb_next, qb_reg, qb_next;
    logic [OUT_W-1:0] tp_reg, tp_next, tq_reg, tq_next;

    logic signed [RW-1:0] ea_reg, ea_next, eb_reg, eb_next;
    logic signed [RW-1:0] fa_reg, fa_next, fb_reg, fb_next;
    logic signed [RW-1:0] ne_reg, ne_next, nf_reg, nf_next;

    logic [NW-1:0]  r_reg, r_next, mr_reg, mr_next;
    logic [AW-1:0]  acc_reg, acc_next, mx_reg, mx_next;
    logic [SCW-1:0] steps_reg, steps_next;
    status_t        status_reg, status_next;

    logic [AW-1:0] lo_w, hi_w, init_ea, init_fa, mul_sum;
    logic          in_bad;
    logic          ea_pos, eb_pos, fa_pos, fb_pos, ne_pos;
    logic          div_start, done_a, done_b;
    logic [NW-1:0] q_a, q_b, r0, r1, r_sel;
    logic [SW-1:0] steps_ext;
    logic [STEP_W-1:0] steps_sat;

    assign lo_w    = AW'(item.lower_bound);
    assign hi_w    = AW'(item.upper_bound);
    assign in_bad  = (lo_w > SCALE) || (hi_w > SCALE) || (lo_w > hi_w);
    assign init_ea = SCALE - lo_w;
    assign init_fa = SCALE - hi_w;

    assign ea_pos = !ea_reg[RW-1] && (ea_reg != '0);
    assign eb_pos = !eb_reg[RW-1] && (eb_reg != '0);
    assign fa_pos = !fa_reg[RW-1] && (fa_reg != '0);
    assign fb_pos = !fb_reg[RW-1] && (fb_reg != '0);
    assign ne_pos = !ne_reg[RW-1] && (ne_reg != '0);

    // floor(ea/eb) and ceil(fa/fb), zero when either operand is not positive
    sri_div #(.W(NW)) u_sri_div_e (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .round_up (1'b0),
        .dividend (ea_reg[NW-1:0]),
        .divisor  (eb_reg[NW-1:0]),
        .done     (done_a),
        .quotient (q_a)
    );

    sri_div #(.W(NW)) u_sri_div_f (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .round_up (1'b1),
        .dividend (fa_reg[NW-1:0]),
        .divisor  (fb_reg[NW-1:0]),
        .done     (done_b),
        .quotient (q_b)
    );

    assign r0    = (ea_pos && eb_pos) ? q_a : '0;
    assign r1    = (fa_pos && fb_pos) ? q_b : '0;
    assign r_sel = !eb_pos ? r1 : (!fb_pos ? r0 : ((r0 < r1) ? r0 : r1));

    assign mul_sum = ((op_reg == OP_E) || (op_reg == OP_F)) ? (acc_reg - mx_reg)
                                                           : (acc_reg + mx_reg);

    assign steps_ext = SW'(steps_reg);
    assign steps_sat = (steps_ext > SW'(STEP_MAX)) ? STEP_W'(STEP_MAX)
                                                   : steps_ext[STEP_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        pa_next     = pa_reg;
        qa_next     = qa_reg;
        pb_next     = pb_reg;
        qb_next     = qb_reg;
        tp_next     = tp_reg;
        tq_next     = tq_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        fa_next     = fa_reg;
        fb_next     = fb_reg;
        ne_next     = ne_reg;
        nf_next     = nf_reg;
        r_next      = r_reg;
        mr_next     = mr_reg;
        acc_next    = acc_reg;
        mx_next     = mx_reg;
        steps_next  = steps_reg;
        status_next = status_reg;
        div_start   = 1'b0;

        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    pa_next     = '0;
                    qa_next     = OUT_W'(1);
                    pb_next     = OUT_W'(1);
                    qb_next     = OUT_W'(1);
                    steps_next  = '0;
                    ea_next     = init_ea[RW-1:0];
                    eb_next     = lo_w[RW-1:0];
                    fa_next     = init_fa[RW-1:0];
                    fb_next     = hi_w[RW-1:0];
                    status_next = STATUS_OK;
                    if (in_bad)
                    begin
                        status_next = STATUS_INVALID;
                        state_next  = ST_FINISH;
                    end
                    else if (lo_w == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (steps_reg >= SCW'(MAX_STEPS))
                begin
                    status_next = STATUS_CAP;
                    state_next  = ST_FINISH;
                end
                else if (!eb_pos && !fb_pos)
                begin
                    status_next = STATUS_INVALID;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    steps_next = steps_reg + SCW'(1);
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (done_a && done_b)
                begin
                    r_next     = r_sel;
                    op_next    = OP_P;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                mr_next = r_reg;
                unique case (op_reg)
                    OP_P:
                    begin
                        acc_next = AW'(pb_reg);
                        mx_next  = AW'(pa_reg);
                    end
                    OP_Q:
                    begin
                        acc_next = AW'(qb_reg);
                        mx_next  = AW'(qa_reg);
                    end
                    OP_E:
                    begin
                        acc_next = AW'(fa_reg);
                        mx_next  = AW'(fb_reg);
                    end
                    OP_F:
                    begin
                        acc_next = AW'(ea_reg);
                        mx_next  = AW'(eb_reg);
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (mr_reg == '0)
                begin
                    state_next = ST_LOAD;
                    unique case (op_reg)
                        OP_P:
                        begin
                            tp_next = acc_reg[OUT_W-1:0];
                            op_next = OP_Q;
                        end
                        OP_Q:
                        begin
                            tq_next = acc_reg[OUT_W-1:0];
                            op_next = OP_E;
                        end
                        OP_E:
                        begin
                            ne_next = acc_reg[RW-1:0];
                            op_next = OP_F;
                        end
                        OP_F:
                        begin
                            nf_next    = acc_reg[RW-1:0];
                            state_next = ST_UPDATE;
                        end
                        default:
                        begin
                            state_next = ST_UPDATE;
                        end
                    endcase
                end
                else
                begin
                    if (mr_reg[0])
                    begin
                        acc_next = mul_sum;
                    end
                    mx_next = mx_reg << 1;
                    mr_next = mr_reg >> 1;
                end
            end
            ST_UPDATE:
            begin
                pb_next = pa_reg;
                qb_next = qa_reg;
                pa_next = tp_reg;
                qa_next = tq_reg;
                fa_next = eb_reg;
                ea_next = fb_reg;
                eb_next = ne_reg;
                fb_next = nf_reg;
                // carry on while the new lower residual is positive or the upper negative
                if (ne_pos || nf_reg[RW-1])
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.numerator   = pa_reg;
                    result_next.denominator = qa_reg;
                    result_next.step_count  = steps_sat;
                    result_next.status      = status_reg;
                    result_valid_next       = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= OP_P;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        pa_reg     <= pa_next;
        qa_reg     <= qa_next;
        pb_reg     <= pb_next;
        qb_reg     <= qb_next;
        tp_reg     <= tp_next;
        tq_reg     <= tq_next;
        ea_reg     <= ea_next;
        eb_reg     <= eb_next;
        fa_reg     <= fa_next;
        fb_reg     <= fb_next;
        ne_reg     <= ne_next;
        nf_reg     <= nf_next;
        r_reg      <= r_next;
        mr_reg     <= mr_next;
        acc_reg    <= acc_next;
        mx_reg     <= mx_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

[rtl/sri_checker.sv]
// Port-level assertions for the smallest-denominator fraction block, bound to the top.
// Depends on sri_pkg and smallest_rational_in_interval.
`default_nettype none

module sri_checker #(
    parameter int MAX_STEPS = sri_pkg::MAX_STEPS_DEFAULT
) (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input sri_pkg::result_t result
);
    import sri_pkg::*;

    localparam int STEP_MAX  = (2 ** STEP_W) - 1;
    localparam int CAP_STEPS = (MAX_STEPS > STEP_MAX) ? STEP_MAX : MAX_STEPS;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed before transaction completed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input taken again while a transaction is in progress");

    a_zero_steps: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.step_count == '0) |->
            (result.numerator == '0) && (result.denominator == OUT_W'(1)) &&
            ((result.status == STATUS_OK) || (result.status == STATUS_INVALID)))
        else $error("no iteration run but result is not 0/1");

    a_cap_steps: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == STATUS_CAP) |->
            (result.step_count == STEP_W'(CAP_STEPS)))
        else $error("iteration cap flagged with wrong step count");

endmodule

bind smallest_rational_in_interval sri_checker #(.MAX_STEPS(MAX_STEPS)) u_sri_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
